// File: hdl/dmgp_pkg.sv
package dmgp_pkg;

  localparam int OUT_W      = 48;
  localparam int ACC_W      = 64;
  localparam int PROD_W     = 58;
  localparam int NUM_FIELDS = 10;
  localparam int NUM_OUT    = 10;
  localparam int NUM_JOBS   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_BASIS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_ORDER = 2'd1;

  localparam logic [1:0] ORDER_DENSITY  = 2'd0;
  localparam logic [1:0] ORDER_GRADIENT = 2'd1;
  localparam logic [1:0] ORDER_HESSIAN  = 2'd2;

  localparam logic [1:0] VEC_LAST_DENSITY = 2'd0;
  localparam logic [1:0] VEC_LAST_HESS    = 2'd3;
  localparam logic [3:0] JOB_LAST_DENSITY = 4'd0;
  localparam logic [3:0] JOB_LAST_GRAD    = 4'd3;
  localparam logic [3:0] JOB_LAST_HESS    = 4'd15;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sd140737488355327;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sd140737488355328;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV,
    ST_MV_DRAIN,
    ST_DOT,
    ST_END_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       vld;
    logic       dot;
    logic [3:0] sel;
    logic       first;
    logic       last;
  } tag_t;

  // vector operand of a dot job: 0 phi'P, 1..3 d_a'P
  function automatic logic [1:0] job_vec(input logic [3:0] j);
    logic [1:0] r;
    unique case (j)
      4'd10, 4'd11, 4'd12: r = 2'd1;
      4'd13, 4'd14:        r = 2'd2;
      4'd15:               r = 2'd3;
      default:             r = 2'd0;
    endcase
    return r;
  endfunction

  // sample field of a dot job: 0 phi, 1..3 d, 4..9 h
  function automatic logic [3:0] job_field(input logic [3:0] j);
    logic [3:0] r;
    unique case (j)
      4'd10:               r = 4'd1;
      4'd11, 4'd13:        r = 4'd2;
      4'd12, 4'd14, 4'd15: r = 4'd3;
      default:             r = j;
    endcase
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > SAT_MAX) r = SAT_MAX[OUT_W-1:0];
    else if (x < SAT_MIN) r = SAT_MIN[OUT_W-1:0];
    else r = x[OUT_W-1:0];
    return r;
  endfunction

endpackage

// File: hdl/density_matrix_on_grid_point_core.sv
// Channel   | Dir | Payload
// s_axis    | in  | tuser: kind; tdata: function_index, value_word, deriv_x..z, second_xx..zz
// m_axis    | out | tdata: density, grad_x..z, hess_xx..zz (48 bits each)
// cfg       | in  | cfg_index_i 0 basis_count, 1 derivative_order
// The final sample of a point starts one shared MAC over the matrix and sample memories:
// per column, nk*n matrix reads (nk = 1, or 4 at order 2), a pipeline drain and nj dot
// terms (1, 4 or 16). Inputs stall during that pass; results sit in an output register,
// so inputs are taken while a result waits. Reset clears counters, state and output valid
// and sets basis_count 64, order 0; the memories and accumulators are not cleared.
module density_matrix_on_grid_point_core #(
  parameter int MAX_BASIS    = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // function_index, value_word, deriv_x, deriv_y, deriv_z, second_xx, second_xy,
  // second_xz, second_yy, second_yz, second_zz, zero fill
  input  logic [359:0]                         s_axis_tdata,
  // kind
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // density, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz, hess_yy, hess_yz, hess_zz
  output logic [479:0]                         m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [dmgp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dmgp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int SE   = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
  localparam int IW   = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int NW   = $clog2(MAX_BASIS + 1);
  localparam int NNW  = 2 * NW;
  localparam int MD   = MAX_BASIS * MAX_BASIS;
  localparam int AW   = (MD > 1) ? $clog2(MD) : 1;
  localparam int SMW  = dmgp_pkg::NUM_FIELDS * SE;
  localparam int OW   = dmgp_pkg::OUT_W;
  localparam int CW   = dmgp_pkg::ACC_W;

  logic [6:0] basis_count_q;
  logic [1:0] deriv_order_q;
  logic [AW-1:0] wptr_q;
  logic [6:0] fcnt_q;

  dmgp_pkg::state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic [IW-1:0] a_q, a_d, b_q, b_d;
  logic [3:0] j_q, j_d;
  logic [AW-1:0] rb_q, rb_d;

  logic [SE-1:0] mmem [MD];
  logic [SMW-1:0] smem [MAX_BASIS];
  logic [SE-1:0] mrd_q;
  logic [SMW-1:0] srd_q;
  logic [AW-1:0] maddr;
  logic [IW-1:0] saddr;

  dmgp_pkg::tag_t iss, p1_q, p2_q, p3_q;
  logic signed [55:0] ph_q;
  logic signed [56:0] pl_q;
  logic signed [dmgp_pkg::PROD_W-1:0] prod_q;
  logic signed [OW-1:0] v_q [4];
  logic signed [CW-1:0] mvacc_q;
  logic signed [CW-1:0] acc_q [dmgp_pkg::NUM_JOBS];
  logic signed [OW-1:0] out_q [dmgp_pkg::NUM_OUT];
  logic out_vld_q;

  logic [31:0] n_full;
  logic [NW-1:0] n, n_m1;
  logic [NNW-1:0] nn;
  logic [1:0] ord, k_last;
  logic [3:0] j_last;
  logic pipe_empty, fin_go, in_acc, is_mat, is_smp, due, swe;
  logic [AW-1:0] wp_eff, wp_inc;
  logic [7:0] fcnt_inc;

  always_comb begin
    if (basis_count_q == 7'd0) n_full = 32'd1;
    else if (32'(basis_count_q) > MAX_BASIS) n_full = 32'(MAX_BASIS);
    else n_full = 32'(basis_count_q);
  end
  assign n    = n_full[NW-1:0];
  assign n_m1 = n - NW'(1);
  assign nn   = NNW'(n) * NNW'(n);
  assign ord  = (deriv_order_q > dmgp_pkg::ORDER_HESSIAN) ? dmgp_pkg::ORDER_HESSIAN
                                                          : deriv_order_q;
  assign k_last = (ord == dmgp_pkg::ORDER_HESSIAN) ? dmgp_pkg::VEC_LAST_HESS
                                                   : dmgp_pkg::VEC_LAST_DENSITY;
  always_comb begin
    unique case (ord)
      dmgp_pkg::ORDER_DENSITY:  j_last = dmgp_pkg::JOB_LAST_DENSITY;
      dmgp_pkg::ORDER_GRADIENT: j_last = dmgp_pkg::JOB_LAST_GRAD;
      default:                  j_last = dmgp_pkg::JOB_LAST_HESS;
    endcase
  end

  assign pipe_empty = !p1_q.vld && !p2_q.vld && !p3_q.vld;
  assign s_axis_tready = (state_q == dmgp_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign is_mat = in_acc && !s_axis_tuser;
  assign is_smp = in_acc && s_axis_tuser;
  assign fcnt_inc = 8'(fcnt_q) + 8'd1;
  assign due = is_smp && ((NNW + 1)'(fcnt_inc) >= (NNW + 1)'(n));
  assign swe = is_smp && (32'(s_axis_tdata[5:0]) < MAX_BASIS);
  assign wp_eff = ((NNW + 1)'(wptr_q) >= (NNW + 1)'(nn)) ? '0 : wptr_q;
  assign wp_inc = wp_eff + AW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d = k_q;
    a_d = a_q;
    b_d = b_q;
    j_d = j_q;
    rb_d = rb_q;
    iss = '0;
    fin_go = 1'b0;
    maddr = AW'(rb_q + AW'(b_q));
    saddr = b_q;
    unique case (state_q)
      dmgp_pkg::ST_IDLE: begin
        if (due) begin
          state_d = dmgp_pkg::ST_MV;
          k_d = '0;
          a_d = '0;
          b_d = '0;
          j_d = '0;
          rb_d = '0;
        end
      end
      dmgp_pkg::ST_MV: begin
        saddr = a_q;
        iss.vld = 1'b1;
        iss.sel = 4'(k_q);
        iss.first = (a_q == '0);
        iss.last = (NW'(a_q) == n_m1);
        if (NW'(a_q) == n_m1) begin
          a_d = '0;
          rb_d = '0;
          if (k_q == k_last) begin
            k_d = '0;
            state_d = dmgp_pkg::ST_MV_DRAIN;
          end else begin
            k_d = k_q + 2'd1;
          end
        end else begin
          a_d = a_q + IW'(1);
          rb_d = rb_q + AW'(n);
        end
      end
      dmgp_pkg::ST_MV_DRAIN: begin
        if (pipe_empty) state_d = dmgp_pkg::ST_DOT;
      end
      dmgp_pkg::ST_DOT: begin
        iss.vld = 1'b1;
        iss.dot = 1'b1;
        iss.sel = j_q;
        iss.first = (b_q == '0);
        if (j_q == j_last) begin
          j_d = '0;
          if (NW'(b_q) == n_m1) begin
            state_d = dmgp_pkg::ST_END_DRAIN;
          end else begin
            b_d = b_q + IW'(1);
            state_d = dmgp_pkg::ST_MV;
          end
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      dmgp_pkg::ST_END_DRAIN: begin
        if (pipe_empty) state_d = dmgp_pkg::ST_FIN;
      end
      dmgp_pkg::ST_FIN: begin
        if (!out_vld_q || m_axis_tready) begin
          fin_go = 1'b1;
          state_d = dmgp_pkg::ST_IDLE;
        end
      end
      default: state_d = dmgp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmgp_pkg::ST_IDLE;
      k_q <= '0;
      a_q <= '0;
      b_q <= '0;
      j_q <= '0;
      rb_q <= '0;
      basis_count_q <= 7'd64;
      deriv_order_q <= 2'd0;
      wptr_q <= '0;
      fcnt_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      a_q <= a_d;
      b_q <= b_d;
      j_q <= j_d;
      rb_q <= rb_d;
      p1_q <= iss;
      p2_q <= p1_q;
      p3_q <= p2_q;
      if (cfg_we_i) begin
        if (cfg_index_i == dmgp_pkg::REG_BASIS_COUNT) basis_count_q <= cfg_data_i;
        else if (cfg_index_i == dmgp_pkg::REG_DERIV_ORDER) deriv_order_q <= cfg_data_i[1:0];
      end
      if (is_mat) begin
        wptr_q <= ((NNW + 1)'(wp_inc) >= (NNW + 1)'(nn)) ? '0 : wp_inc;
      end
      if (is_smp) fcnt_q <= due ? '0 : fcnt_inc[6:0];
      if (fin_go) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (is_mat) mmem[wp_eff] <= s_axis_tdata[6 +: SE];
    mrd_q <= mmem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (swe) begin
      for (int f = 0; f < dmgp_pkg::NUM_FIELDS; f++) begin
        smem[IW'(s_axis_tdata[5:0])][f*SE +: SE] <= s_axis_tdata[6 + 32*f +: SE];
      end
    end
    srd_q <= smem[saddr];
  end

  // shared MAC: operand select and split multiply
  logic [3:0] fsel;
  logic [SE-1:0] fraw;
  logic signed [OW-1:0] opa;
  logic signed [31:0] opb;
  logic signed [23:0] hi;
  logic signed [56:0] plr;

  assign fsel = p1_q.dot ? dmgp_pkg::job_field(p1_q.sel) : p1_q.sel;
  assign fraw = srd_q[fsel*SE +: SE];
  always_comb begin
    if (p1_q.dot) begin
      opa = v_q[dmgp_pkg::job_vec(p1_q.sel)];
      opb = {{(32-SE){fraw[SE-1]}}, fraw};
    end else begin
      opa = {{(OW-SE){fraw[SE-1]}}, fraw};
      opb = {{(32-SE){mrd_q[SE-1]}}, mrd_q};
    end
  end
  assign hi  = opa[OW-1:24];
  assign plr = pl_q + 57'sd8388608;

  always_ff @(posedge clk_i) begin
    ph_q <= hi * opb;
    pl_q <= $signed({1'b0, opa[23:0]}) * opb;
    prod_q <= dmgp_pkg::PROD_W'(ph_q) + dmgp_pkg::PROD_W'($signed(plr[56:24]));
  end

  logic signed [CW-1:0] mv_sum, dot_sum;
  assign mv_sum  = p3_q.first ? CW'(prod_q) : mvacc_q + CW'(prod_q);
  assign dot_sum = p3_q.first ? CW'(prod_q) : acc_q[p3_q.sel] + CW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (p3_q.vld) begin
      if (p3_q.dot) begin
        acc_q[p3_q.sel] <= dot_sum;
      end else begin
        mvacc_q <= mv_sum;
        if (p3_q.last) v_q[p3_q.sel[1:0]] <= dmgp_pkg::sat48(mv_sum);
      end
    end
  end

  // result
  logic signed [OW-1:0] res [dmgp_pkg::NUM_OUT];
  logic signed [OW-1:0] g, s1, s2;
  always_comb begin
    g = '0;
    s1 = '0;
    s2 = '0;
    for (int i = 0; i < dmgp_pkg::NUM_OUT; i++) res[i] = '0;
    res[0] = dmgp_pkg::sat48(acc_q[0]);
    if (ord != dmgp_pkg::ORDER_DENSITY) begin
      for (int i = 1; i < 4; i++) begin
        g = dmgp_pkg::sat48(acc_q[i]);
        res[i] = dmgp_pkg::sat48(CW'(g) + CW'(g));
      end
    end
    if (ord == dmgp_pkg::ORDER_HESSIAN) begin
      for (int i = 0; i < 6; i++) begin
        s1 = dmgp_pkg::sat48(acc_q[4+i]);
        s2 = dmgp_pkg::sat48(acc_q[10+i]);
        res[4+i] = dmgp_pkg::sat48((CW'(s1) + CW'(s2)) + (CW'(s1) + CW'(s2)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      for (int i = 0; i < dmgp_pkg::NUM_OUT; i++) out_q[i] <= res[i];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  always_comb begin
    for (int i = 0; i < dmgp_pkg::NUM_OUT; i++) m_axis_tdata[i*OW +: OW] = out_q[i];
  end

`ifndef SYNTHESIS
  a_fin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmgp_pkg::ST_FIN) |-> pipe_empty) else $error("MAC busy at finish");
  a_dot_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmgp_pkg::ST_DOT && j_q == '0) |-> !p3_q.vld || p3_q.dot)
    else $error("dot term overlaps vector build");
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmgp_pkg::ST_MV) |-> (NW'(a_q) <= n_m1 && NW'(b_q) <= n_m1))
    else $error("row index out of range");
  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_vld_q && fcnt_q == '0) else $error("result without cleared count");
`endif

endmodule

// File: test/density_matrix_on_grid_point_core_tb.sv
`timescale 1ns / 1ps

module density_matrix_on_grid_point_core_tb;

  localparam int MAXB = 64;
  localparam int LIMIT = 1000000;
  localparam logic [dmgp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam longint P48 = 64'sd140737488355327;
  localparam longint N48 = -64'sd140737488355328;

  typedef struct {
    logic         kind;
    logic [359:0] data;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [359:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [479:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [dmgp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [dmgp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  density_matrix_on_grid_point_core u_dut (.*);

  request_t     pending_q[$];
  logic [479:0] density_q[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit send_burst = 0;
  bit recv_burst = 0;
  int pushed = 0;

  // mirror of the block state
  int     mat[MAXB*MAXB];
  int     phi[MAXB];
  int     d1[MAXB][3];
  int     d2[MAXB][6];
  int     wr_ptr = 0;
  int     fn_count = 0;
  int     basis_reg = 64;
  int     order_reg = 0;
  longint phi_p[MAXB];
  longint d_p[3][MAXB];

  initial forever #2 clk_i = ~clk_i;

  function automatic longint sat48(longint x);
    if (x > P48) return P48;
    if (x < N48) return N48;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint hi, lo;
    hi = a >>> 24;
    lo = a - (hi <<< 24);
    return hi * b + ((lo * b + 64'sd8388608) >>> 24);
  endfunction

  function automatic int eff_n();
    if (basis_reg == 0) return 1;
    if (basis_reg > MAXB) return MAXB;
    return basis_reg;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h3ffffff) - 32'h2000000;
    endcase
  endfunction

  task automatic density_point();
    int n, ord, f, c, k;
    longint acc;
    longint res[10];
    logic [479:0] packed_res;
    int pa[6] = '{0, 0, 0, 1, 1, 2};
    int pb[6] = '{0, 1, 2, 1, 2, 2};
    n = eff_n();
    ord = (order_reg > 2) ? 2 : order_reg;
    foreach (res[j]) res[j] = 0;
    for (c = 0; c < n; c++) begin
      acc = 0;
      for (f = 0; f < n; f++) acc += qmul(phi[f], mat[f*n+c]);
      phi_p[c] = sat48(acc);
    end
    acc = 0;
    for (f = 0; f < n; f++) acc += qmul(phi_p[f], phi[f]);
    res[0] = sat48(acc);
    if (ord >= 1) begin
      for (k = 0; k < 3; k++) begin
        acc = 0;
        for (f = 0; f < n; f++) acc += qmul(phi_p[f], d1[f][k]);
        res[1+k] = sat48(2 * sat48(acc));
      end
    end
    if (ord >= 2) begin
      for (k = 0; k < 3; k++) begin
        for (c = 0; c < n; c++) begin
          acc = 0;
          for (f = 0; f < n; f++) acc += qmul(d1[f][k], mat[f*n+c]);
          d_p[k][c] = sat48(acc);
        end
      end
      for (k = 0; k < 6; k++) begin
        longint s1, s2;
        s1 = 0;
        s2 = 0;
        for (f = 0; f < n; f++) begin
          s1 += qmul(phi_p[f], d2[f][k]);
          s2 += qmul(d_p[pa[k]][f], d1[f][pb[k]]);
        end
        res[4+k] = sat48(2 * (sat48(s1) + sat48(s2)));
      end
    end
    for (k = 0; k < 10; k++) packed_res[48*k +: 48] = res[k][47:0];
    density_q = {density_q, packed_res};
  endtask

  task automatic apply_request(logic kind, logic [359:0] d);
    int n, f, k;
    n = eff_n();
    if (kind == KIND_MATRIX) begin
      if (wr_ptr >= n * n) wr_ptr = 0;
      mat[wr_ptr] = $signed(d[6 +: 32]);
      wr_ptr++;
      if (wr_ptr >= n * n) wr_ptr = 0;
    end else begin
      f = d[5:0];
      phi[f] = $signed(d[6 +: 32]);
      for (k = 0; k < 3; k++) d1[f][k] = $signed(d[6+32*(1+k) +: 32]);
      for (k = 0; k < 6; k++) d2[f][k] = $signed(d[6+32*(4+k) +: 32]);
      fn_count++;
      if (fn_count >= n) begin
        fn_count = 0;
        density_point();
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    request_t it;
    bit busy;
    if (rst_ni) begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tuser, s_axis_tdata);
        busy = 0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          s_axis_tdata <= it.data;
          s_axis_tuser <= it.kind;
          busy = 1;
          send_gap = pick_gap(send_burst);
        end
        s_axis_tvalid <= busy;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [479:0] exp_v;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (density_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_v = density_q.pop_front();
          for (int k = 0; k < 10; k++)
            if (exp_v[48*k +: 48] !== m_axis_tdata[48*k +: 48]) begin
              $display("%0t: field %0d expected %h actual %h", $time, k,
                       exp_v[48*k +: 48], m_axis_tdata[48*k +: 48]);
              errors++;
            end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = pick_gap(recv_burst);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || s_axis_tvalid || density_q.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dmgp_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[dmgp_pkg::CFG_DATA_W-1:0];
    if (idx == dmgp_pkg::REG_BASIS_COUNT) basis_reg = val & 32'h7f;
    else if (idx == dmgp_pkg::REG_DERIV_ORDER) order_reg = val & 3;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_request(logic kind, int fidx);
    request_t it;
    int rnd;
    for (int k = 0; k < 10; k++) it.data[6+32*k +: 32] = rand_word();
    it.data[359:326] = '0;
    it.data[5:0] = fidx[5:0];
    if (kind == KIND_MATRIX) begin
      rnd = $urandom;
      it.data[5:0] = rnd[5:0];
    end
    it.kind = kind;
    pending_q = {pending_q, it};
    pushed++;
  endtask

  task automatic run_phase(int nb, int ord, int points, bit load, int stray);
    int n, f, tmp;
    int perm[MAXB];
    for (int i = 0; i < stray; i++) push_request(KIND_MATRIX, 0);
    wait_idle();
    send_burst = ($urandom_range(0, 3) == 0);
    recv_burst = ($urandom_range(0, 3) == 0);
    write_reg(dmgp_pkg::REG_BASIS_COUNT, nb);
    write_reg(dmgp_pkg::REG_DERIV_ORDER, ord);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
    n = eff_n();
    if (load) for (int i = 0; i < n * n; i++) push_request(KIND_MATRIX, 0);
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      f = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[f];
      perm[f] = tmp;
    end
    for (int p = 0; p < points; p++)
      for (int i = 0; i < n; i++)
        push_request(KIND_SAMPLE, (p == 0 || n == MAXB) ? perm[i] : $urandom_range(0, n - 1));
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(1, 0, 3, 1, 0);
    run_phase(0, 1, 2, 1, 0);
    run_phase(2, 2, 3, 1, 0);
    run_phase(3, 3, 2, 1, 0);
    // grow to 8, then shrink to 2 while the 8x8 matrix is half loaded
    run_phase(8, 2, 1, 1, 0);
    run_phase(2, 1, 2, 1, 30);
    while (pushed < 1850) begin
      run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4),
                $urandom_range(0, 3), $urandom_range(3, 10), 1, $urandom_range(0, 6));
    end
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/dmgp_pkg.sv
hdl/density_matrix_on_grid_point_core.sv
test/density_matrix_on_grid_point_core_tb.sv
